>>> design/dis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dis_pkg
// Shared types and constants for the decimal integer scanner.
// ----------------------------------------------------------------------------
package dis_pkg;

    localparam int VALUE_BITS = 32;
    localparam int CONS_BITS  = 16;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [35:0] LIMIT_SIGNED   = 36'h0_7FFF_FFFF;
    localparam logic [35:0] LIMIT_UNSIGNED = 36'h0_FFFF_FFFF;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_NAN = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_LEAD   = 5'b00010,
        PH_SIGNED = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_TRAIL  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic       start_req;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value_bits;
        logic [1:0]            status;
        logic [CONS_BITS-1:0]  consumed;
    } out_item_t;

    typedef struct packed {
        phase_t                phase;
        logic [VALUE_BITS-1:0] magnitude;
        logic                  negative;
    } scan_state_t;

endpackage

>>> design/dis_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dis_step
// Next-state and result logic for one character of a scan.
// ----------------------------------------------------------------------------
module dis_step
    import dis_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  in_item_t              item,
    input  logic                  signed_mode,
    input  scan_state_t           cur,
    input  logic [COUNT_BITS-1:0] cur_count,
    output scan_state_t           nxt,
    output logic [COUNT_BITS-1:0] nxt_count,
    output logic                  res_valid,
    output out_item_t             res
);

    scan_state_t           eff;
    logic [COUNT_BITS-1:0] eff_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic [7:0]            c;
    logic                  is_white;
    logic                  is_digit;
    logic                  is_sign;
    logic [35:0]           acc;
    logic [35:0]           limit;
    logic                  ovf;
    logic [1:0]            fin_status;

    assign c = item.char_code;

    // start_req restarts the scan on this very character
    always_comb
    begin
        if (item.start_req)
        begin
            eff.phase     = PH_LEAD;
            eff.magnitude = '0;
            eff.negative  = 1'b0;
            eff_count     = '0;
        end
        else
        begin
            eff       = cur;
            eff_count = cur_count;
        end
    end

    assign inc_count = (&eff_count) ? eff_count : eff_count + 1'b1;

    assign is_white = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_sign  = (c == CH_MINUS) || (c == CH_PLUS);

    // magnitude * 10 as shift-add, plus the digit
    assign acc   = {1'b0, eff.magnitude, 3'b000} + {3'b000, eff.magnitude, 1'b0}
                 + {32'd0, c[3:0]};
    assign limit = signed_mode ? LIMIT_SIGNED : LIMIT_UNSIGNED;
    assign ovf   = acc > limit;

    always_comb
    begin
        nxt        = eff;
        nxt_count  = eff_count;
        res_valid  = 1'b0;
        fin_status = ST_OK;
        unique case (eff.phase) inside
            PH_IDLE:
            begin
                nxt = cur;
                nxt_count = cur_count;
            end
            PH_LEAD, PH_SIGNED:
            begin
                if ((eff.phase == PH_LEAD) && is_white)
                begin
                    nxt_count = inc_count;
                end
                else if ((eff.phase == PH_LEAD) && signed_mode && is_sign)
                begin
                    nxt.negative = (c == CH_MINUS);
                    nxt.phase    = PH_SIGNED;
                    nxt_count    = inc_count;
                end
                else if (!is_digit)
                begin
                    res_valid  = 1'b1;
                    fin_status = ST_NAN;
                end
                else if (ovf)
                begin
                    res_valid  = 1'b1;
                    fin_status = ST_OVF;
                end
                else
                begin
                    nxt.magnitude = acc[31:0];
                    nxt.phase     = PH_DIGITS;
                    nxt_count     = inc_count;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit)
                begin
                    if (ovf)
                    begin
                        res_valid  = 1'b1;
                        fin_status = ST_OVF;
                    end
                    else
                    begin
                        nxt.magnitude = acc[31:0];
                        nxt_count     = inc_count;
                    end
                end
                else if (is_white)
                begin
                    nxt.phase = PH_TRAIL;
                    nxt_count = inc_count;
                end
                else
                begin
                    res_valid = 1'b1;
                end
            end
            PH_TRAIL:
            begin
                if (is_white)
                begin
                    nxt_count = inc_count;
                end
                else
                begin
                    res_valid = 1'b1;
                end
            end
            default:
            begin
                nxt.phase = PH_IDLE;
            end
        endcase
        if (res_valid)
        begin
            nxt.phase = PH_IDLE;
        end
    end

    always_comb
    begin
        res.status   = fin_status;
        res.consumed = CONS_BITS'(eff_count);
        if (fin_status != ST_OK)
        begin
            res.value_bits = '0;
        end
        else if (eff.negative)
        begin
            res.value_bits = 32'd0 - eff.magnitude;
        end
        else
        begin
            res.value_bits = eff.magnitude;
        end
    end

endmodule

>>> design/decimal_integer_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_integer_scanner_core
// Streaming decimal string to integer scanner, one character per beat.
// ----------------------------------------------------------------------------
// Takes one character beat per clock and returns at most one result beat per
// scan. Leading whitespace is skipped, an optional sign is taken in signed
// mode, digits accumulate into a 32-bit magnitude and trailing whitespace is
// skipped; the first other character ends the scan. Throughput is one
// character per cycle, sustained, as long as result beats are taken; while a
// result beat is stalled at the output, one more character is still taken
// into the input register, and input then stalls until the result is taken.
// A character beat is held in the input register, then goes through the step
// logic (shift-add multiply by ten, digit add, limit compare) into the result
// register. signed_mode may be written only while no character beat or result
// beat is in flight.
// ----------------------------------------------------------------------------
module decimal_integer_scanner_core
    import dis_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    // input stage
    logic     in_valid_reg;
    in_item_t in_data_reg;

    // scan state
    scan_state_t           state_reg;
    scan_state_t           state_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  signed_mode_reg;

    // result stage
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic      res_valid;
    out_item_t res;
    logic      step_fire;

    // the step runs whenever a character waits and the result slot is free
    // or being emptied this cycle
    assign step_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step_fire;

    dis_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .item        (in_data_reg),
        .signed_mode (signed_mode_reg),
        .cur         (state_reg),
        .cur_count   (count_reg),
        .nxt         (state_next),
        .nxt_count   (count_next),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase     <= PH_IDLE;
            state_reg.magnitude <= '0;
            state_reg.negative  <= 1'b0;
            count_reg           <= '0;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            signed_mode_reg <= cfg_wdata;
        end
    end

    // result register: loaded by a step that ends a scan, cleared when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> design/dis_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dis_checker
// Port-level assertions for the decimal integer scanner, bound to the core.
// ----------------------------------------------------------------------------
module dis_checker
    import dis_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // stalled character beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("character beat changed while stalled");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // input only stalls when the result slot is full and blocked
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == ST_OK) || (out_data.status == ST_NAN)
                   || (out_data.status == ST_OVF))
        else $error("bad status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |-> out_data.value_bits == '0)
        else $error("error result with nonzero value");

endmodule

bind decimal_integer_scanner_core dis_checker u_dis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the decimal integer scanner core.
// ----------------------------------------------------------------------------
// Streams character beats into the scanner. A scoreboard class tracks the
// scan state for every accepted character beat, queues the result each one
// causes, and compares result beats in order, field by field. The run covers
// short directed strings and random scans under four idle/stall mixes.
// signed_mode changes only while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb;
    import dis_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 6;     // settle time after the last expected result
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BEATS    = 275;
    localparam logic [CONS_BITS-1:0] COUNT_CAP = '1;

    // ------------------------------------------------------------------------
    // Scoreboard: scan tracker plus queue of expected result beats
    // ------------------------------------------------------------------------
    class scan_scoreboard;
        out_item_t             pending_results[$];
        int                    errors;
        logic                  signed_mode;
        phase_t                ph;
        logic [VALUE_BITS-1:0] mag;
        logic                  neg;
        logic [CONS_BITS-1:0]  count;

        function new();
            errors      = 0;
            signed_mode = 1'b1;
            ph          = PH_IDLE;
            mag         = '0;
            neg         = 1'b0;
            count       = '0;
        endfunction

        function bit is_space(logic [7:0] c);
            return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function void bump();
            if (count != COUNT_CAP)
                count++;
        endfunction

        function void emit(logic [1:0] st);
            out_item_t r;
            r.value_bits = '0;
            if (st == ST_OK)
                r.value_bits = neg ? (32'd0 - mag) : mag;
            r.status   = st;
            r.consumed = count;
            pending_results.push_back(r);
            ph = PH_IDLE;
        endfunction

        // Multiply-add one digit; 0 when it would pass the mode's limit.
        function bit take_digit(logic [7:0] c);
            logic [35:0] next;
            logic [35:0] limit;
            next  = 36'(mag) * 36'd10 + 36'(c - CH_ZERO);
            limit = signed_mode ? LIMIT_SIGNED : LIMIT_UNSIGNED;
            if (next > limit)
                return 1'b0;
            mag = next[VALUE_BITS-1:0];
            return 1'b1;
        endfunction

        function void first_digit(logic [7:0] c);
            if (!is_digit(c))
                emit(ST_NAN);
            else if (!take_digit(c))
                emit(ST_OVF);
            else
            begin
                bump();
                ph = PH_DIGITS;
            end
        endfunction

        function void note_char(in_item_t b);
            logic [7:0] c;
            c = b.char_code;
            if (b.start_req)
            begin
                ph    = PH_LEAD;
                mag   = '0;
                neg   = 1'b0;
                count = '0;
            end
            case (ph)
                PH_LEAD:
                begin
                    if (is_space(c))
                        bump();
                    else if (signed_mode && (c == CH_MINUS || c == CH_PLUS))
                    begin
                        neg = (c == CH_MINUS);
                        bump();
                        ph = PH_SIGNED;
                    end
                    else
                        first_digit(c);
                end
                PH_SIGNED: first_digit(c);
                PH_DIGITS:
                begin
                    if (is_digit(c))
                    begin
                        if (!take_digit(c))
                            emit(ST_OVF);
                        else
                            bump();
                    end
                    else if (is_space(c))
                    begin
                        bump();
                        ph = PH_TRAIL;
                    end
                    else
                        emit(ST_OK);
                end
                PH_TRAIL:
                begin
                    if (is_space(c))
                        bump();
                    else
                        emit(ST_OK);
                end
                default: ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result beat with none expected: value %h status %0d consumed %0d",
                         $time, got.value_bits, got.status, got.consumed);
                errors++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (got.value_bits !== exp.value_bits)
                begin
                    $display("%0t ns: value_bits expected %h actual %h",
                             $time, exp.value_bits, got.value_bits);
                    errors++;
                end
                if (got.status !== exp.status)
                begin
                    $display("%0t ns: status expected %0d actual %0d",
                             $time, exp.status, got.status);
                    errors++;
                end
                if (got.consumed !== exp.consumed)
                begin
                    $display("%0t ns: consumed expected %0d actual %0d",
                             $time, exp.consumed, got.consumed);
                    errors++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int beats_sent = 0;

    scan_scoreboard sb;

    decimal_integer_scanner_core #(
        .COUNT_BITS (16)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Receiver: random stall per cycle at the current rate
    always @(posedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= stall_pct);

    // Result monitor: values seen here are the ones sampled at the edge
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);

    // Watchdog: ends the run after too many cycles with no beat on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_char(input logic start, input logic [7:0] c);
        in_item_t beat;
        beat.start_req = start;
        beat.char_code = c;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_char(beat);
        beats_sent++;
    endtask

    // First char of the text carries start_req
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(i == 0, s[i]);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.signed_mode = m;
    endtask

    // Tab, line feed, vertical tab, form feed, carriage return or space
    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    // Digit text, biased toward the signed and unsigned limits
    function automatic string number_text();
        longint unsigned v;
        string s;
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            v = $urandom_range(1) ? 64'd2147483647 : 64'd4294967295;
            v = v + 64'($urandom_range(4));
            v = v - 64'd2;
        end
        else if (pick < 40)
            v = 64'($urandom) * 64'($urandom_range(1, 25));
        else if (pick < 70)
            v = 64'($urandom_range(999));
        else
            v = 64'($urandom);
        s = $sformatf("%0d", v);
        if ($urandom_range(9) == 0)
            s = {"0", s};
        return s;
    endfunction

    task automatic random_scan();
        string digits;
        int kind;
        int n;
        int r;
        logic lead;
        logic [7:0] c;
        kind = $urandom_range(99);
        lead = 1'b1;
        if (kind < 72)
        begin
            // well-formed: spaces, optional sign, digits, spaces, stop char
            n = $urandom_range(3);
            repeat (n)
            begin
                send_char(lead, pick_space());
                lead = 1'b0;
            end
            if ($urandom_range(2) == 0)
            begin
                send_char(lead, $urandom_range(1) ? CH_MINUS : CH_PLUS);
                lead = 1'b0;
            end
            digits = number_text();
            for (int i = 0; i < digits.len(); i++)
            begin
                send_char(lead, digits[i]);
                lead = 1'b0;
            end
            n = $urandom_range(2);
            repeat (n) send_char(1'b0, pick_space());
            if ($urandom_range(2) == 0)
                c = 8'h00;
            else
                do
                    c = 8'($urandom_range(255));
                while (sb.is_space(c));
            send_char(1'b0, c);
            // tail after the result is ignored until the next start
            n = $urandom_range(2);
            repeat (n) send_char(1'b0, 8'($urandom_range(255)));
        end
        else if (kind < 82)
        begin
            // noise, occasional start mid-stream
            n = $urandom_range(1, 5);
            repeat (n) send_char($urandom_range(4) == 0, 8'($urandom_range(255)));
        end
        else
        begin
            // broken scans: mix of digits, spaces, signs, any byte
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
            begin
                r = $urandom_range(3);
                case (r)
                    0: c = CH_ZERO + 8'($urandom_range(9));
                    1: c = pick_space();
                    2: c = $urandom_range(1) ? CH_MINUS : CH_PLUS;
                    default: c = 8'($urandom_range(255));
                endcase
                send_char(i == 0, c);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    int idle_mix[4]  = '{0, 53, 0, 15};
    int stall_mix[4] = '{0, 0, 53, 15};

    initial
    begin
        int target;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // negative zero with leading space, zero byte ends it
        send_text(" -0");
        send_char(1'b0, 8'h00);
        // plus sign, trailing space, letter ends it
        send_text("+7 x");
        // not a number on the first char, and right after a sign
        send_text("a");
        send_text("-q");
        // restart mid-scan drops the first scan
        send_text("12");
        send_text("5;");
        // char without start while idle: no result
        send_char(1'b0, "9");
        // mode change inside a scan
        send_text("4");
        write_mode(1'b0);
        send_char(1'b0, "2");
        send_char(1'b0, " ");
        send_char(1'b0, "!");
        // sign in unsigned mode
        send_text("-");
        write_mode(1'b1);

        for (int p = 0; p < 4; p++)
        begin
            write_mode(p[0]);
            idle_pct  = idle_mix[p];
            stall_pct = stall_mix[p];
            target    = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
            begin
                random_scan();
                if ($urandom_range(9) == 0)
                    write_mode(1'($urandom_range(1)));
            end
        end

        drain_results();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
